### rtl/save_image_section_verifier_top_defines.svh
// Assertion macros for the save image section verifier.
// Used by the top level only; relies on clk and rst_n in the including scope.
`ifndef SAVE_IMAGE_SECTION_VERIFIER_TOP_DEFINES_SVH
`define SAVE_IMAGE_SECTION_VERIFIER_TOP_DEFINES_SVH

// Antecedent and consequent in the same cycle
`define SVE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sve assertion failed");

// Consequent in the cycle after the antecedent
`define SVE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sve assertion failed");

`endif

### rtl/sve_pkg.sv
// Shared types, constants and a helper function of the save image section verifier.
// No dependencies.
package sve_pkg;

    localparam int unsigned SECTION_WORDS = 1024;
    localparam int unsigned FOOTER_WORD   = 1021;
    localparam int unsigned SECTION_COUNT = 14;
    localparam int unsigned SNAP_COUNT    = 8;

    localparam int unsigned WP_W   = $clog2(SECTION_WORDS);
    localparam int unsigned SLOT_W = $clog2(SECTION_COUNT);
    localparam int unsigned SNAP_W = $clog2(SNAP_COUNT);
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [WP_W-1:0] FOOTER_POS = WP_W'(FOOTER_WORD);
    localparam logic [WP_W-1:0] SIG_POS    = WP_W'(FOOTER_WORD + 1);
    localparam logic [WP_W-1:0] INDEX_POS  = WP_W'(FOOTER_WORD + 2);
    localparam logic [WP_W-1:0] LAST_POS   = WP_W'(SECTION_WORDS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SECTION_COUNT - 1);
    localparam logic [SECTION_COUNT-1:0] ALL_IDS = '1;

    // byte lengths covered by each snapshot
    localparam int unsigned SNAP_BYTES [SNAP_COUNT] = '{
        3884, 3848, 2192, 3136, 3876, 3816, 3968, 2000
    };

    // snapshot slots
    localparam logic [SNAP_W-1:0] SNAP_ID0_MAIN  = 3'd0;
    localparam logic [SNAP_W-1:0] SNAP_ID4_MAIN  = 3'd1;
    localparam logic [SNAP_W-1:0] SNAP_ID0_OLD_A = 3'd2;
    localparam logic [SNAP_W-1:0] SNAP_ID4_OLD_A = 3'd3;
    localparam logic [SNAP_W-1:0] SNAP_ID0_OLD_B = 3'd4;
    localparam logic [SNAP_W-1:0] SNAP_ID4_OLD_B = 3'd5;
    localparam logic [SNAP_W-1:0] SNAP_GENERAL   = 3'd6;
    localparam logic [SNAP_W-1:0] SNAP_TAIL      = 3'd7;

    // section ids with their own length
    localparam logic [SLOT_W-1:0] SEC_ID_A    = 4'd0;
    localparam logic [SLOT_W-1:0] SEC_ID_B    = 4'd4;
    localparam logic [SLOT_W-1:0] SEC_ID_TAIL = 4'd13;

    // game modes
    localparam logic [1:0] MODE_MAIN  = 2'd0;
    localparam logic [1:0] MODE_OLD_A = 2'd1;
    localparam logic [1:0] MODE_OLD_B = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GAME_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOOTER_SIG = 2'd1;

    typedef struct packed {
        logic [31:0] image_word;
        logic        image_start;
    } in_item_t;

    typedef struct packed {
        logic        block_number;
        logic [3:0]  slot_number;
        logic [15:0] footer_id;
        logic [15:0] stored_sum;
        logic [15:0] computed_sum;
        logic        sum_mismatch;
        logic        id_out_of_range;
        logic        image_done;
        logic        first_block_valid;
        logic        second_block_valid;
        logic        active_block;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  game_mode;
        logic [31:0] footer_signature;
    } cfg_regs_t;

    function automatic logic [SNAP_W-1:0] pick_snapshot(input logic [1:0] mode,
                                                        input logic [SLOT_W-1:0] id);
        logic [SNAP_W-1:0] sel;
        sel = SNAP_GENERAL;
        if (id == SEC_ID_A) begin
            case (mode)
                MODE_OLD_A: sel = SNAP_ID0_OLD_A;
                MODE_OLD_B: sel = SNAP_ID0_OLD_B;
                default:    sel = SNAP_ID0_MAIN;
            endcase
        end else if (id == SEC_ID_B) begin
            case (mode)
                MODE_OLD_A: sel = SNAP_ID4_OLD_A;
                MODE_OLD_B: sel = SNAP_ID4_OLD_B;
                default:    sel = SNAP_ID4_MAIN;
            endcase
        end else if (id == SEC_ID_TAIL) begin
            sel = SNAP_TAIL;
        end
        return sel;
    endfunction

endpackage

### rtl/sve_in_reg.sv
// Input register of the verifier: holds one image word transaction.
// Depends on sve_pkg.
module sve_in_reg
    import sve_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  logic     advance,
    output logic     held_valid,
    output in_item_t held_data
);

    logic     valid_reg;
    in_item_t data_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

### rtl/sve_core.sv
// Section state and per-word processing: running sum, snapshots, footer checks, block validity.
// Depends on sve_pkg.
module sve_core
    import sve_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_regs_t cfg,
    output logic      last,
    output out_item_t result
);

    logic [WP_W-1:0]          word_pos_reg, word_pos_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic                     block_reg, block_next;
    logic [31:0]              sum_reg, sum_next;
    logic [31:0]              snap_reg [SNAP_COUNT];
    logic [31:0]              snap_next [SNAP_COUNT];
    logic [31:0]              footer_reg, footer_next;
    logic                     sig_ok_reg, sig_ok_next;
    logic [SECTION_COUNT-1:0] mask_reg, mask_next;
    logic [31:0]              ref_idx_reg, ref_idx_next;
    logic                     ref_set_reg, ref_set_next;
    logic                     bsv_reg, bsv_next;
    logic [31:0]              saved_idx_reg, saved_idx_next;
    logic                     saved_valid_reg, saved_valid_next;

    logic [WP_W-1:0]   pos_eff;
    logic [SLOT_W-1:0] slot_eff;
    logic              block_eff;
    logic [31:0]       saved_idx_eff;
    logic              saved_valid_eff;
    logic [15:0]       fid;
    logic              oor;
    logic [31:0]       snap_sel;
    logic [15:0]       calc;
    logic              blk_ok;

    always_comb
    begin
        // image_start clears per-image state ahead of the word
        pos_eff         = item.image_start ? '0 : word_pos_reg;
        slot_eff        = item.image_start ? '0 : slot_reg;
        block_eff       = item.image_start ? 1'b0 : block_reg;
        saved_idx_eff   = item.image_start ? '0 : saved_idx_reg;
        saved_valid_eff = item.image_start ? 1'b0 : saved_valid_reg;
        mask_next       = item.image_start ? '0 : mask_reg;
        ref_idx_next    = item.image_start ? '0 : ref_idx_reg;
        ref_set_next    = item.image_start ? 1'b0 : ref_set_reg;
        bsv_next        = item.image_start ? 1'b1 : bsv_reg;
        sig_ok_next     = item.image_start ? 1'b0 : sig_ok_reg;

        sum_next = ((pos_eff == '0) ? 32'd0 : sum_reg) + item.image_word;

        for (int i = 0; i < SNAP_COUNT; i++)
        begin
            snap_next[i] = snap_reg[i];
            if (pos_eff == WP_W'(SNAP_BYTES[i] / 4 - 1))
            begin
                snap_next[i] = sum_next;
            end
        end

        footer_next = (pos_eff == FOOTER_POS) ? item.image_word : footer_reg;
        fid = footer_next[15:0];
        oor = fid >= 16'(SECTION_COUNT);

        if (pos_eff == SIG_POS)
        begin
            sig_ok_next = item.image_word == cfg.footer_signature;
        end

        if (pos_eff == INDEX_POS)
        begin
            if (!sig_ok_next || oor)
            begin
                bsv_next = 1'b0;
            end
            else
            begin
                mask_next[fid[SLOT_W-1:0]] = 1'b1;
                if (!ref_set_next)
                begin
                    ref_idx_next = item.image_word;
                    ref_set_next = 1'b1;
                end
                else if (item.image_word != ref_idx_next)
                begin
                    bsv_next = 1'b0;
                end
            end
        end

        last     = pos_eff == LAST_POS;
        // every snapshot is taken before the footer, so the stored copy is current here
        snap_sel = snap_reg[pick_snapshot(cfg.game_mode, fid[SLOT_W-1:0])];
        calc     = oor ? 16'd0 : 16'(snap_sel[15:0] + snap_sel[31:16]);
        blk_ok   = bsv_next && (mask_next == ALL_IDS);

        result.block_number       = block_eff;
        result.slot_number        = 4'(slot_eff);
        result.footer_id          = fid;
        result.stored_sum         = footer_next[31:16];
        result.computed_sum       = calc;
        result.sum_mismatch       = !oor && (calc != footer_next[31:16]);
        result.id_out_of_range    = oor;
        result.image_done         = 1'b0;
        result.first_block_valid  = 1'b0;
        result.second_block_valid = 1'b0;
        result.active_block       = 1'b0;

        word_pos_next    = pos_eff + WP_W'(1);
        slot_next        = slot_eff;
        block_next       = block_eff;
        saved_idx_next   = saved_idx_eff;
        saved_valid_next = saved_valid_eff;

        if (last)
        begin
            word_pos_next = '0;
            if (slot_eff != SLOT_LAST)
            begin
                slot_next = slot_eff + SLOT_W'(1);
            end
            else
            begin
                slot_next = '0;
                if (!block_eff)
                begin
                    saved_valid_next = blk_ok;
                    saved_idx_next   = ref_idx_next;
                    block_next       = 1'b1;
                end
                else
                begin
                    result.image_done         = 1'b1;
                    result.first_block_valid  = saved_valid_eff;
                    result.second_block_valid = blk_ok;
                    if (saved_valid_eff && blk_ok)
                    begin
                        result.active_block = ref_idx_next > saved_idx_eff;
                    end
                    else
                    begin
                        result.active_block = blk_ok;
                    end
                    block_next       = 1'b0;
                    sum_next         = '0;
                    saved_valid_next = 1'b0;
                    saved_idx_next   = '0;
                end
                // new block either way
                mask_next    = '0;
                ref_idx_next = '0;
                ref_set_next = 1'b0;
                bsv_next     = 1'b1;
                sig_ok_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_pos_reg    <= '0;
            slot_reg        <= '0;
            block_reg       <= 1'b0;
            sum_reg         <= '0;
            sig_ok_reg      <= 1'b0;
            mask_reg        <= '0;
            ref_idx_reg     <= '0;
            ref_set_reg     <= 1'b0;
            bsv_reg         <= 1'b1;
            saved_idx_reg   <= '0;
            saved_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            word_pos_reg    <= word_pos_next;
            slot_reg        <= slot_next;
            block_reg       <= block_next;
            sum_reg         <= sum_next;
            sig_ok_reg      <= sig_ok_next;
            mask_reg        <= mask_next;
            ref_idx_reg     <= ref_idx_next;
            ref_set_reg     <= ref_set_next;
            bsv_reg         <= bsv_next;
            saved_idx_reg   <= saved_idx_next;
            saved_valid_reg <= saved_valid_next;
        end
    end

    // snapshot and footer stores are valid once written, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            footer_reg <= footer_next;
            for (int i = 0; i < SNAP_COUNT; i++)
            begin
                snap_reg[i] <= snap_next[i];
            end
        end
    end

endmodule

### rtl/sve_out_reg.sv
// Result register of the verifier: holds one section result until taken.
// Depends on sve_pkg.
module sve_out_reg
    import sve_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t load_data,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      valid_reg, valid_next;
    out_item_t data_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = (valid_reg && !out_ready) || load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

### rtl/save_image_section_verifier_top.sv
// Save image section verifier, top level: configuration registers, pipeline glue, checks.
// Depends on sve_pkg, sve_in_reg, sve_core, sve_out_reg and the assertion macro header.

// One image word per cycle in steady state, unless a waiting result holds a last word. A word
// passes from the input register through the section logic into the result register, so the
// result of the last word of a section is registered in both before it is presented; every
// other word gives no result. A result left waiting stalls only the last word of the
// following section, and words in between keep flowing. game_mode and footer_signature are
// written by cfg_index 0 and 1, by the user only while the block is idle (not enforced).
// Other indexes are ignored. Assert image_start on the first word of an image.
`include "save_image_section_verifier_top_defines.svh"

module save_image_section_verifier_top
    import sve_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    cfg_regs_t cfg_reg;
    logic      held_valid;
    in_item_t  held_data;
    logic      advance;
    logic      core_last;
    out_item_t core_result;
    logic      can_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GAME_MODE:  cfg_reg.game_mode <= cfg_data[1:0];
                CFG_FOOTER_SIG: cfg_reg.footer_signature <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign advance = held_valid && (!core_last || can_load);

    sve_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .advance    (advance),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    sve_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (held_data),
        .cfg    (cfg_reg),
        .last   (core_last),
        .result (core_result)
    );

    sve_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && core_last),
        .load_data (core_result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `SVE_ASSERT_IMPL(a_done_on_last_slot, out_valid && out_data.image_done,
        out_data.block_number && (out_data.slot_number == 4'(SECTION_COUNT - 1)))
    `SVE_ASSERT_IMPL(a_oor_not_compared, out_valid && out_data.id_out_of_range,
        !out_data.sum_mismatch && (out_data.computed_sum == 16'd0))
    `SVE_ASSERT_IMPL(a_summary_only_when_done, out_valid && !out_data.image_done,
        !out_data.first_block_valid && !out_data.second_block_valid && !out_data.active_block)
    `SVE_ASSERT_NEXT(a_result_load_sets_valid, advance && core_last, out_valid)

endmodule
